### hdl/ppt_pkg.sv
// Package for the pulse period tachometer: widths, constants, register
// indexes, sequencer state codes and the divider status type.
// No dependencies.
`default_nettype none

package ppt_pkg;

    localparam int LOG_DEPTH = 1024;

    localparam int TIME_W    = 32;
    localparam int MIN_W     = 20;
    localparam int SPEED_W   = 26;
    localparam int SAMPLE_W  = 11;
    localparam int ELAPSED_W = 42;
    localparam int LOG_CNT_W = $clog2(LOG_DEPTH + 1);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = 1 + SPEED_W + 1 + TIME_W + SAMPLE_W + ELAPSED_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = MIN_W;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE         = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL = 1'd1;

    localparam logic [MIN_W-1:0]     MIN_INTERVAL_RESET = 20'd2000;
    localparam logic [SPEED_W-1:0]   RPM_NUMERATOR      = 26'd60000000;
    localparam logic [LOG_CNT_W-1:0] LOG_DEPTH_C        = LOG_CNT_W'(LOG_DEPTH);

    localparam int DIV_STEPS = SPEED_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### hdl/ppt_div.sv
// Iterative restoring divider that computes the RPM numerator divided by
// a 32-bit interval, one quotient bit per cycle. Depends on ppt_pkg.
`default_nettype none

module ppt_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ppt_pkg::TIME_W-1:0]    divisor,
    output ppt_pkg::div_stat_t                 stat,
    output logic [ppt_pkg::SPEED_W-1:0]        quotient
);
    import ppt_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_W-1:0]    divisor_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [SPEED_W-1:0]   work_reg;

    logic [TIME_W:0]      rem_shift;
    logic                 q_bit;
    logic [TIME_W:0]      rem_diff;
    logic [TIME_W-1:0]    rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, work_reg[SPEED_W-1]};
        q_bit     = rem_shift >= {1'b0, divisor_reg};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        rem_next  = q_bit ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            work_reg    <= RPM_NUMERATOR;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            work_reg <= {work_reg[SPEED_W-2:0], q_bit};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;

endmodule

`default_nettype wire

### hdl/pulse_period_tachometer.sv
// Pulse period tachometer: one result transaction per edge timestamp.
// Each result is registered; a new speed waits for the divider before it is emitted.
// Edges are handled one at a time; a speed division, one bit per cycle, slows the rate.
// Input is not ready while an edge is in work or its result waits to be registered.
// Async active-low reset rst_n clears control state; min_interval returns to 2000.
// Depends on ppt_pkg and ppt_div.
`default_nettype none

module pulse_period_tachometer
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // tdata: edge_time[31:0]
    input  wire logic [ppt_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata: accepted[0], speed_rpm[26:1], logged[27], interval_us[59:28],
    // sample_number[70:60], elapsed_us[112:71], zero fill[119:113]
    output logic [ppt_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_wen,
    input  wire logic [ppt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [ppt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ppt_pkg::*;

    logic [1:0]           state_reg;
    logic                 mode_reg;
    logic [MIN_W-1:0]     min_interval_reg;
    logic [TIME_W-1:0]    last_edge_reg;
    logic                 have_prev_reg;
    logic [SPEED_W-1:0]   held_speed_reg;
    logic [LOG_CNT_W-1:0] log_count_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 accepted_reg;
    logic                 logged_reg;
    logic [TIME_W-1:0]    interval_reg;
    logic                 m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                 in_fire;
    logic [TIME_W-1:0]    interval;
    logic                 acc;
    logic                 log_ok;
    logic                 need_div;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic                 out_free;
    logic [OUT_FIELD_W-1:0] out_fields;

    div_stat_t            div_stat;
    logic [SPEED_W-1:0]   div_quotient;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        interval     = s_tdata[TIME_W-1:0] - last_edge_reg;
        acc          = interval >= {{(TIME_W - MIN_W){1'b0}}, min_interval_reg};
        log_ok       = acc && mode_reg && have_prev_reg && (log_count_reg < LOG_DEPTH_C);
        need_div     = acc && !mode_reg && (interval != '0);
        elapsed_sum  = {1'b0, elapsed_reg} + {{(ELAPSED_W + 1 - TIME_W){1'b0}}, interval};
        elapsed_next = elapsed_sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : elapsed_sum[ELAPSED_W-1:0];
        out_fields   = {elapsed_reg, SAMPLE_W'(log_count_reg), interval_reg, logged_reg,
                        held_speed_reg, accepted_reg};
    end

    ppt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire && need_div),
        .divisor  (interval),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mode_reg         <= 1'b0;
            min_interval_reg <= MIN_INTERVAL_RESET;
            last_edge_reg    <= '0;
            have_prev_reg    <= 1'b0;
            held_speed_reg   <= '0;
            log_count_reg    <= '0;
            elapsed_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_EMIT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wen)
            begin
                case (cfg_addr)
                    REG_MODE:
                    begin
                        mode_reg      <= cfg_wdata[0];
                        log_count_reg <= '0;
                        elapsed_reg   <= '0;
                    end
                    REG_MIN_INTERVAL:
                    begin
                        min_interval_reg <= cfg_wdata;
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (acc)
                        begin
                            last_edge_reg <= s_tdata[TIME_W-1:0];
                            have_prev_reg <= 1'b1;
                            if (!mode_reg && (interval == '0))
                            begin
                                held_speed_reg <= RPM_NUMERATOR;
                            end
                        end
                        if (log_ok)
                        begin
                            elapsed_reg   <= elapsed_next;
                            log_count_reg <= log_count_reg + 1'b1;
                        end
                        state_reg <= need_div ? ST_DIV : ST_EMIT;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        held_speed_reg <= div_quotient;
                        state_reg      <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            accepted_reg <= acc;
            logged_reg   <= log_ok;
            interval_reg <= interval;
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            m_tdata_reg <= OUT_TDATA_W'(out_fields);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
